/* hw/rtl/bidirectional_flow_table_core_defines.svh */
// ----------------------------------------------------------------------------
// Flow table assertion macros
// Shared helpers for concurrent checks, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BIDIRECTIONAL_FLOW_TABLE_CORE_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_TABLE_CORE_DEFINES_SVH

// Same-cycle implication
`define BFT_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BFT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/bft_pkg.sv */
// ----------------------------------------------------------------------------
// Flow table package
// Sizes, item structs, result kinds and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bft_pkg;

  // Table geometry (BUCKETS must be a power of two)
  localparam int BUCKETS = 1024;
  localparam int WAYS    = 4;
  localparam int BKT_W   = $clog2(BUCKETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Result kinds
  localparam logic [1:0] KIND_EXPORT = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // Action codes
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] length;
    logic [31:0] time_seconds;
    logic [9:0]  bucket;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  flow_protocol;
    logic [31:0] flow_src_addr;
    logic [15:0] flow_src_port;
    logic [31:0] flow_dst_addr;
    logic [15:0] flow_dst_port;
    logic [31:0] packet_count;
    logic [31:0] byte_count;
    logic        last;
  } out_item_t;

  // One flow slot
  typedef struct packed {
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] packets;
    logic [31:0] bytes;
    logic [31:0] first_time;
    logic [31:0] last_time;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  // Controller to datapath
  typedef struct packed {
    logic             clear;
    logic [BKT_W-1:0] clr_idx;
    logic             load;
    logic             read;
    logic             eval;
    logic             update;
    logic             drop_out;
    logic             export_out;
    logic             done_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_sweep;
    logic hit;
    logic has_free;
    logic pending;
    logic out_free;
  } status_t;

  // Lowest set bit of a way mask
  function automatic logic [WAY_W-1:0] low_way(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) idx = WAY_W'(i);
    end
    return idx;
  endfunction

endpackage

/* hw/rtl/bidirectional_flow_table_core.sv */
// ----------------------------------------------------------------------------
// Bidirectional flow table core
// Hashed flow cache with packet update and per-bucket timeout sweep.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_item_i   (bft_pkg::in_item_t)
// out       output     out_valid_o/out_stall_i out_item_o (bft_pkg::out_item_t)
// cfg       input      cfg_we_i               cfg_wdata_i (flow timeout)
//
// Packet steps: accept, bucket read, way compare, write-back or drop.
// A sweep, after its compare, issues each exported flow and the done marker,
// each set by the single result register and the one valid-memory write port.
// After reset a clearing pass over all BUCKETS (1024) rows empties the valid
// memory; no item is accepted during it.
// A stalled output holds the result and the controller waits in place.
// ----------------------------------------------------------------------------
module bidirectional_flow_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bft_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bft_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import bft_pkg::*;

  cmd_t    cmd;
  status_t status;

  bft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bft_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* hw/rtl/bft_datapath.sv */
// ----------------------------------------------------------------------------
// Flow table datapath
// Bucket memories, way compare, expiry test, write-back and result register.
// ----------------------------------------------------------------------------
module bft_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bft_pkg::in_item_t  in_item_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  bft_pkg::cmd_t      cmd_i,
  output bft_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bft_pkg::out_item_t out_item_o
);
  import bft_pkg::*;

  row_t             entry_mem [BUCKETS];
  logic [WAYS-1:0]  valid_mem [BUCKETS];

  in_item_t         item_q;
  logic [15:0]      timeout_q;
  row_t             row_q;
  logic [WAYS-1:0]  vrow_q;
  logic [WAYS-1:0]  match_q, free_q, pend_q;
  logic [WAYS-1:0]  match_d, free_d, exp_d;
  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        out_d;

  logic [31:0]      addr_sum;
  logic [BKT_W-1:0] bidx;
  logic             in_range;
  logic [WAY_W-1:0] upd_way, exp_way;
  entry_t           new_entry;
  row_t             row_wdata;
  logic [WAYS-1:0]  vrow_wdata;
  logic             vwe;
  logic [BKT_W-1:0] vaddr;
  logic [WAYS-1:0]  vdata;
  logic             out_load;
  logic             out_free;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 16'd5;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
  end

  // Bucket index: hash for packets, given bucket for sweeps
  assign addr_sum = item_q.src_addr + item_q.dst_addr;
  assign in_range = (32'(item_q.bucket) < 32'(BUCKETS));
  assign bidx     = (item_q.action == ACT_SWEEP) ? BKT_W'(item_q.bucket)
                                                 : addr_sum[BKT_W-1:0];

  // Way compare and expiry test, all ways in parallel
  always_comb begin
    logic [32:0] span, idle;
    logic        a_ok, p_ok;
    for (int w = 0; w < WAYS; w++) begin
      a_ok = (row_q[w].src_addr == item_q.src_addr && row_q[w].dst_addr == item_q.dst_addr)
          || (row_q[w].src_addr == item_q.dst_addr && row_q[w].dst_addr == item_q.src_addr);
      p_ok = (row_q[w].src_port == item_q.src_port && row_q[w].dst_port == item_q.dst_port)
          || (row_q[w].src_port == item_q.dst_port && row_q[w].dst_port == item_q.src_port);
      match_d[w] = vrow_q[w] && (row_q[w].protocol == item_q.protocol) && a_ok && p_ok;
      free_d[w]  = !vrow_q[w];
      span = {1'b0, row_q[w].last_time} - {1'b0, row_q[w].first_time};
      idle = {1'b0, item_q.time_seconds} - {1'b0, row_q[w].last_time};
      exp_d[w] = vrow_q[w] && in_range
              && ((!span[32] && span[31:0] > {16'b0, timeout_q})
               || (!idle[32] && idle[31:0] > {16'b0, timeout_q}));
    end
  end

  // Compare results
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      match_q <= match_d;
      free_q  <= free_d;
    end
  end

  // Pending exports, dropped one by one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (cmd_i.eval) begin
      pend_q <= exp_d;
    end else if (cmd_i.export_out) begin
      pend_q[exp_way] <= 1'b0;
    end
  end

  // Way choice for a packet: matching way first, else lowest free way
  assign upd_way = (|match_q) ? low_way(match_q) : low_way(free_q);
  assign exp_way = low_way(pend_q);

  always_comb begin
    new_entry = row_q[upd_way];
    if (|match_q) begin
      new_entry.packets   = row_q[upd_way].packets + 32'd1;
      new_entry.bytes     = row_q[upd_way].bytes + {16'b0, item_q.length};
      new_entry.last_time = item_q.time_seconds;
    end else begin
      new_entry.protocol   = item_q.protocol;
      new_entry.src_addr   = item_q.src_addr;
      new_entry.dst_addr   = item_q.dst_addr;
      new_entry.src_port   = item_q.src_port;
      new_entry.dst_port   = item_q.dst_port;
      new_entry.packets    = 32'd1;
      new_entry.bytes      = {16'b0, item_q.length};
      new_entry.first_time = item_q.time_seconds;
      new_entry.last_time  = item_q.time_seconds;
    end
    row_wdata          = row_q;
    row_wdata[upd_way] = new_entry;
  end

  // Valid row write data
  always_comb begin
    vrow_wdata = vrow_q;
    if (cmd_i.update) vrow_wdata[upd_way] = 1'b1;
    if (cmd_i.export_out) vrow_wdata[exp_way] = 1'b0;
  end

  assign vwe   = cmd_i.clear || cmd_i.update || cmd_i.export_out;
  assign vaddr = cmd_i.clear ? cmd_i.clr_idx : bidx;
  assign vdata = cmd_i.clear ? '0 : vrow_wdata;

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      entry_mem[bidx] <= row_wdata;
    end
    if (cmd_i.read) begin
      row_q <= entry_mem[bidx];
    end
  end

  // Valid memory
  always_ff @(posedge clk_i) begin
    if (vwe) begin
      valid_mem[vaddr] <= vdata;
    end
  end

  // Working copy of the valid row
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      vrow_q <= valid_mem[bidx];
    end else if (cmd_i.update || cmd_i.export_out) begin
      vrow_q <= vrow_wdata;
    end
  end

  // Result register
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.drop_out || cmd_i.export_out || cmd_i.done_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Next result item
  always_comb begin
    out_d = '0;
    if (cmd_i.drop_out) begin
      out_d.kind          = KIND_DROP;
      out_d.flow_protocol = item_q.protocol;
      out_d.flow_src_addr = item_q.src_addr;
      out_d.flow_src_port = item_q.src_port;
      out_d.flow_dst_addr = item_q.dst_addr;
      out_d.flow_dst_port = item_q.dst_port;
      out_d.last          = 1'b1;
    end else if (cmd_i.export_out) begin
      out_d.kind          = KIND_EXPORT;
      out_d.flow_protocol = row_q[exp_way].protocol;
      out_d.flow_src_addr = row_q[exp_way].src_addr;
      out_d.flow_src_port = row_q[exp_way].src_port;
      out_d.flow_dst_addr = row_q[exp_way].dst_addr;
      out_d.flow_dst_port = row_q[exp_way].dst_port;
      out_d.packet_count  = row_q[exp_way].packets;
      out_d.byte_count    = row_q[exp_way].bytes;
    end else begin
      out_d.kind = KIND_DONE;
      out_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o.is_sweep = (item_q.action == ACT_SWEEP);
  assign status_o.hit      = |match_q;
  assign status_o.has_free = |free_q;
  assign status_o.pending  = |pend_q;
  assign status_o.out_free = out_free;

endmodule

/* hw/rtl/bft_ctrl.sv */
// ----------------------------------------------------------------------------
// Flow table controller
// Sequences the clearing pass, bucket read, compare and result issue.
// ----------------------------------------------------------------------------
`include "bidirectional_flow_table_core_defines.svh"

module bft_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bft_pkg::status_t status_i,
  output bft_pkg::cmd_t    cmd_o
);
  import bft_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_SWEEP  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [BKT_W-1:0] clr_q, clr_d;
  logic             accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    cmd_o.clr_idx = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == BKT_W'(BUCKETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (status_i.is_sweep) begin
          state_d = ST_SWEEP;
        end else if (status_i.hit || status_i.has_free) begin
          cmd_o.update = 1'b1;
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.drop_out = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // full bucket, result register busy: wait
          state_d = ST_DECIDE;
        end
      end
      ST_SWEEP: begin
        if (status_i.out_free) begin
          if (status_i.pending) begin
            cmd_o.export_out = 1'b1;
          end else begin
            cmd_o.done_out = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  `BFT_ASSERT_SAME(a_drop_only_when_full, clk_i, rst_ni, cmd_o.drop_out, !status_i.hit && !status_i.has_free, "drop with room in bucket")
  `BFT_ASSERT_SAME(a_export_needs_pending, clk_i, rst_ni, cmd_o.export_out, status_i.pending && status_i.out_free, "export without pending flow")
  `BFT_ASSERT_NEXT(a_load_then_read, clk_i, rst_ni, cmd_o.load, cmd_o.read, "read does not follow item load")

endmodule

/* dv/flow_table_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow table checker
// Watches the input, output and configuration ports of the flow table, keeps
// its own copy of the flow slots and timeout, and compares every result item
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module flow_table_checker
  import bft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow copy of the flow slots
  logic        slot_used [BUCKETS*WAYS];
  entry_t      slot      [BUCKETS*WAYS];
  logic [15:0] timeout_q;
  out_item_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic bit flow_aged(entry_t e, logic [31:0] now);
    longint span;
    longint idle;
    span = longint'(e.last_time) - longint'(e.first_time);
    idle = longint'(now) - longint'(e.last_time);
    return (span > longint'(timeout_q)) || (idle > longint'(timeout_q));
  endfunction

  // Apply one accepted item to the shadow table and queue its results
  task automatic predict_item(in_item_t it);
    int        base;
    int        free_way;
    int        s;
    bit        addr_eq;
    bit        port_eq;
    out_item_t r;
    if (it.action == ACT_PACKET) begin
      base = int'((it.src_addr + it.dst_addr) % BUCKETS) * WAYS;
      free_way = -1;
      for (int w = 0; w < WAYS; w++) begin
        s = base + w;
        if (!slot_used[s]) begin
          if (free_way < 0) free_way = w;
          continue;
        end
        addr_eq = (slot[s].src_addr == it.src_addr && slot[s].dst_addr == it.dst_addr) ||
                  (slot[s].src_addr == it.dst_addr && slot[s].dst_addr == it.src_addr);
        port_eq = (slot[s].src_port == it.src_port && slot[s].dst_port == it.dst_port) ||
                  (slot[s].src_port == it.dst_port && slot[s].dst_port == it.src_port);
        if (slot[s].protocol == it.protocol && addr_eq && port_eq) begin
          slot[s].packets   = slot[s].packets + 1;
          slot[s].bytes     = slot[s].bytes + 32'(it.length);
          slot[s].last_time = it.time_seconds;
          return;
        end
      end
      if (free_way < 0) begin
        r = '0;
        r.kind          = KIND_DROP;
        r.flow_protocol = it.protocol;
        r.flow_src_addr = it.src_addr;
        r.flow_src_port = it.src_port;
        r.flow_dst_addr = it.dst_addr;
        r.flow_dst_port = it.dst_port;
        r.last          = 1'b1;
        expected_q.push_back(r);
        return;
      end
      s = base + free_way;
      slot_used[s] = 1'b1;
      slot[s] = '{protocol: it.protocol, src_addr: it.src_addr, dst_addr: it.dst_addr,
                  src_port: it.src_port, dst_port: it.dst_port, packets: 32'd1,
                  bytes: 32'(it.length), first_time: it.time_seconds,
                  last_time: it.time_seconds};
      return;
    end
    // Sweep: export aged flows in way order, then the done marker
    if (int'(it.bucket) < BUCKETS) begin
      base = int'(it.bucket) * WAYS;
      for (int w = 0; w < WAYS; w++) begin
        s = base + w;
        if (slot_used[s] && flow_aged(slot[s], it.time_seconds)) begin
          r = '0;
          r.kind          = KIND_EXPORT;
          r.flow_protocol = slot[s].protocol;
          r.flow_src_addr = slot[s].src_addr;
          r.flow_src_port = slot[s].src_port;
          r.flow_dst_addr = slot[s].dst_addr;
          r.flow_dst_port = slot[s].dst_port;
          r.packet_count  = slot[s].packets;
          r.byte_count    = slot[s].bytes;
          expected_q.push_back(r);
          slot_used[s] = 1'b0;
        end
      end
    end
    r = '0;
    r.kind = KIND_DONE;
    r.last = 1'b1;
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      timeout_q = 16'd5;
      expected_q.delete();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    end else begin
      if (cfg_we_i) timeout_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_item(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_item_i.kind), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_item_i.kind != want.kind)
            report_mismatch("kind", 64'(out_item_i.kind), 64'(want.kind));
          if (out_item_i.flow_protocol != want.flow_protocol)
            report_mismatch("protocol", 64'(out_item_i.flow_protocol),
                            64'(want.flow_protocol));
          if (out_item_i.flow_src_addr != want.flow_src_addr)
            report_mismatch("src addr", 64'(out_item_i.flow_src_addr),
                            64'(want.flow_src_addr));
          if (out_item_i.flow_src_port != want.flow_src_port)
            report_mismatch("src port", 64'(out_item_i.flow_src_port),
                            64'(want.flow_src_port));
          if (out_item_i.flow_dst_addr != want.flow_dst_addr)
            report_mismatch("dst addr", 64'(out_item_i.flow_dst_addr),
                            64'(want.flow_dst_addr));
          if (out_item_i.flow_dst_port != want.flow_dst_port)
            report_mismatch("dst port", 64'(out_item_i.flow_dst_port),
                            64'(want.flow_dst_port));
          if (out_item_i.packet_count != want.packet_count)
            report_mismatch("packets", 64'(out_item_i.packet_count),
                            64'(want.packet_count));
          if (out_item_i.byte_count != want.byte_count)
            report_mismatch("bytes", 64'(out_item_i.byte_count), 64'(want.byte_count));
          if (out_item_i.last != want.last)
            report_mismatch("last", 64'(out_item_i.last), 64'(want.last));
        end
      end
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Flow table testbench
// Drives packet and sweep items with random gaps and output stalls, steps
// the timeout through several settings, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import bft_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          cycle_count;
  bit          hold_off;
  bit          random_stall;

  // A small pool of host addresses keeps buckets crowded
  logic [31:0] host_pool[8];

  bidirectional_flow_table_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  flow_table_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver stalls: short mostly, occasionally long, plus one long hold-off
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!random_stall) out_stall <= 1'b0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 30) out_stall <= ($urandom_range(0, 3) == 0);
  end

  function automatic int short_gap();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(in_item_t it, bit gaps);
    int idle;
    idle = gaps ? short_gap() : 0;
    repeat (idle) @(posedge clk);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    // the block stalls its input after an accept anyway
    @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t packet_item(logic [7:0] proto, logic [31:0] sa,
                                           logic [31:0] da, logic [15:0] sp,
                                           logic [15:0] dp, logic [15:0] len,
                                           logic [31:0] now);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = ACT_PACKET;
    it.protocol = proto;
    it.src_addr = sa;
    it.dst_addr = da;
    it.src_port = sp;
    it.dst_port = dp;
    it.length = len;
    it.time_seconds = now;
    return it;
  endfunction

  function automatic in_item_t sweep_item(logic [9:0] bkt, logic [31:0] now);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.action = ACT_SWEEP;
    it.bucket = bkt;
    it.time_seconds = now;
    return it;
  endfunction

  function automatic logic [9:0] bucket_of(logic [31:0] sa, logic [31:0] da);
    return 10'((sa + da) % BUCKETS);
  endfunction

  // Random traffic over a few hosts and ports, with sweeps of hot buckets
  task automatic random_phase(int count, logic [31:0] t0);
    logic [31:0] now;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    now = t0;
    for (int n = 0; n < count; n++) begin
      now = now + $urandom_range(0, 3);
      sa = host_pool[$urandom_range(0, 7)];
      da = host_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 9) == 0) begin
        sa = $urandom;
        da = $urandom;
      end
      sp = 16'($urandom_range(0, 5));
      dp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) == 0) now = now - $urandom_range(0, 20);
        send_item(sweep_item($urandom_range(0, 7) == 0 ? 10'($urandom)
                             : bucket_of(sa, da), now + $urandom_range(0, 12)), 1'b1);
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(packet_item(8'($urandom_range(6, 7)), da, sa, dp, sp, 16'($urandom),
                              now), 1'b1);
      end else begin
        send_item(packet_item(8'($urandom_range(6, 7)), sa, da, sp, dp, 16'($urandom),
                              now), 1'b1);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cycle_count = 0;
    hold_off = 1'b0;
    random_stall = 1'b0;
    foreach (host_pool[i]) host_pool[i] = $urandom;
    host_pool[0] = 32'hFFFF_FFFF;
    host_pool[1] = 32'h0000_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-ones fields, reverse match, full bucket, sweeps
    send_item(packet_item(8'hFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'hFFFF, 32'd10),
              1'b0);
    send_item(packet_item(8'hFF, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'hFFFF, 32'd12),
              1'b0);
    send_item(packet_item(8'hFF, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF, 16'd1, 32'd13),
              1'b0);
    // Crossed pairs: addresses swapped but ports not, a match too
    send_item(packet_item(8'hFF, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 16'd2, 32'd14),
              1'b0);
    for (int w = 0; w < WAYS + 1; w++)
      send_item(packet_item(8'(w), 32'h0, 32'h3FF, 16'(w), 16'd0, 16'd0, 32'd0), 1'b0);
    send_item(sweep_item(10'h3FF, 32'd3), 1'b0);
    send_item(sweep_item(10'h3FF, 32'd100), 1'b0);
    send_item(sweep_item(10'h3FF, 32'd0), 1'b0);
    // Sweeps of the now empty bucket at the lowest and highest times
    send_item(sweep_item(10'h3FF, 32'd0), 1'b0);
    send_item(sweep_item(10'h3FF, 32'hFFFF_FFFF), 1'b0);

    // Extremes of the timeout
    write_timeout(16'hFFFF);
    send_item(packet_item(8'd17, 32'd5, 32'd6, 16'd1, 16'd2, 16'd9, 32'd0), 1'b0);
    send_item(sweep_item(10'd11, 32'h0001_0000), 1'b0);
    send_item(sweep_item(10'd11, 32'hFFFF_FFFF), 1'b0);
    write_timeout(16'd0);
    send_item(packet_item(8'd17, 32'd5, 32'd6, 16'd1, 16'd2, 16'd9, 32'd7), 1'b0);
    send_item(sweep_item(10'd11, 32'd7), 1'b0);
    send_item(sweep_item(10'd11, 32'd8), 1'b0);

    // Random phases with stalls, one with a long receiver hold-off
    random_stall = 1'b1;
    write_timeout(16'd3);
    fork
      random_phase(80, 32'd1000);
      begin
        repeat (40) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    write_timeout(16'd0);
    random_phase(60, 32'h7FFF_FF00);
    write_timeout(16'd10);
    random_phase(110, 32'hFFFF_FF80);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bft_pkg.sv
hw/rtl/bft_datapath.sv
hw/rtl/bft_ctrl.sv
hw/rtl/bidirectional_flow_table_core.sv
dv/flow_table_checker.sv
dv/tb_top.sv
